FILE: rtl/rca_pkg.sv
// ----------------------------------------------------------------------------
// rca_pkg: shared types and constants of the RGB16 contrast adjuster
// Item layouts, channel and gain widths, queue depths and operation codes.
// ----------------------------------------------------------------------------
package rca_pkg;

    // Default channel resolution; the ports are always PORT_W bits wide.
    localparam int CHANNEL_BITS_DEF = 16;
    localparam int PORT_W           = 16;

    // Auto gain is unsigned Q8.16.
    localparam int              GAIN_W   = 24;
    localparam int              FRAC_W   = 16;
    localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

    // Contrast factor code that selects auto contrast.
    localparam logic signed [7:0] AUTO_CODE = 8'sh80;

    // Item action codes.
    localparam logic ACT_MEASURE = 1'b0;
    localparam logic ACT_ADJUST  = 1'b1;

    // Queue depths.
    localparam int MQ_DEPTH  = 4;
    localparam int OQ_DEPTH  = 8;
    localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

    // Classified item handed from the front end to the execution side.
    typedef struct packed {
        logic              action;
        logic              first;
        logic [PORT_W-1:0] red;
        logic [PORT_W-1:0] green;
        logic [PORT_W-1:0] blue;
        logic [PORT_W-1:0] opacity;
        logic [PORT_W-1:0] bright;
    } t_item;

    // Finished pixel waiting in the result queue.
    typedef struct packed {
        logic [PORT_W-1:0] red;
        logic [PORT_W-1:0] green;
        logic [PORT_W-1:0] blue;
        logic [PORT_W-1:0] opacity;
    } t_pixel;

endpackage

FILE: rtl/rgb16_contrast_adjust.sv
// ----------------------------------------------------------------------------
// rgb16_contrast_adjust: contrast adjustment of 16-bit RGBA pixels
// Path: front register, middle queue, pipeline stages, then the result queue.
// Throughput: one item per cycle unless credits run out or the gain divider
// runs; an auto adjust item that follows measure items waits for the gain.
// Reset: synchronous, active low; clears queues, statistics, gain and factor.
// No clearing pass is needed; the block takes items right after reset.
// ----------------------------------------------------------------------------
//
// The front end registers each item and computes its brightness. Items then
// wait in a short queue so that the execution side can stall on its own,
// for instance while the auto gain is being divided out. The execution side
// handles measure items by updating the minimum and maximum brightness, and
// sends adjust items through three pipeline stages: gain times deviation,
// scaling (a reciprocal multiply for division by 127, or a shift for the Q8.16
// auto gain), and the final add with clamping. Finished pixels go into a
// result queue; issue is throttled by a credit count so that queue never
// overflows. Once the pipeline and the result queue are full, issue stops and
// the input backs up until the receiver takes a result.
//
// The auto gain is recomputed, one quotient bit per cycle, on the first
// auto adjust item after any measure item.
module rgb16_contrast_adjust
    import rca_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic              i_action,
    input  logic              i_first_of_frame,
    input  logic [PORT_W-1:0] i_in_red,
    input  logic [PORT_W-1:0] i_in_green,
    input  logic [PORT_W-1:0] i_in_blue,
    input  logic [PORT_W-1:0] i_in_opacity,
    output logic              empty,
    input  logic              pop,
    output logic [PORT_W-1:0] o_out_red,
    output logic [PORT_W-1:0] o_out_green,
    output logic [PORT_W-1:0] o_out_blue,
    output logic [PORT_W-1:0] o_out_opacity,
    input  logic              i_cfg_wr_en,
    input  logic [7:0]        i_cfg_wr_data
);

    logic                  mq_push;
    logic                  mq_full;
    logic                  mq_empty;
    logic                  mq_pop;
    t_item                 mq_din;
    logic [$bits(t_item)-1:0] mq_dout;
    t_item                 mq_head;
    logic                  oq_push;
    t_pixel                oq_din;
    logic [$bits(t_pixel)-1:0] oq_dout;
    t_pixel                oq_head;
    logic [OQ_CNT_W-1:0]   oq_count;

    // Front end: takes items from the input and classifies them.
    rca_front #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_action         (i_action),
        .i_first_of_frame (i_first_of_frame),
        .i_in_red         (i_in_red),
        .i_in_green       (i_in_green),
        .i_in_blue        (i_in_blue),
        .i_in_opacity     (i_in_opacity),
        .i_q_full         (mq_full),
        .o_q_push         (mq_push),
        .o_q_item         (mq_din)
    );

    // Queue between the front end and the execution side.
    rca_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (MQ_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mq_push),
        .i_data  (mq_din),
        .i_pop   (mq_pop),
        .o_data  (mq_dout),
        .o_empty (mq_empty),
        .o_full  (mq_full),
        .o_count ()
    );

    assign mq_head = t_item'(mq_dout);

    // Execution side: statistics, gain and the channel pipeline.
    rca_back #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_empty     (mq_empty),
        .i_q_item      (mq_head),
        .o_q_pop       (mq_pop),
        .i_oq_count    (oq_count),
        .o_oq_push     (oq_push),
        .o_oq_pixel    (oq_din)
    );

    // Result queue; the head item is what the result ports show.
    rca_fifo #(
        .WIDTH ($bits(t_pixel)),
        .DEPTH (OQ_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (oq_push),
        .i_data  (oq_din),
        .i_pop   (pop),
        .o_data  (oq_dout),
        .o_empty (empty),
        .o_full  (),
        .o_count (oq_count)
    );

    assign oq_head       = t_pixel'(oq_dout);
    assign o_out_red     = oq_head.red;
    assign o_out_green   = oq_head.green;
    assign o_out_blue    = oq_head.blue;
    assign o_out_opacity = oq_head.opacity;

endmodule

FILE: rtl/rca_fifo.sv
// ----------------------------------------------------------------------------
// rca_fifo: small synchronous first-in first-out queue
// Register based queue with occupancy count; head is shown combinationally.
// ----------------------------------------------------------------------------
module rca_fifo
    import rca_pkg::*;
#(
    parameter int WIDTH = $bits(t_item),
    parameter int DEPTH = MQ_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_empty = (r_cnt == CW'(0));
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? AW'(0) : r_wp + AW'(1);
            end
            if (pop_ok) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? AW'(0) : r_rp + AW'(1);
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: rtl/rca_front.sv
// ----------------------------------------------------------------------------
// rca_front: input stage of the contrast adjuster
// Registers each accepted item and works out its brightness floor((r+g+b)/3).
// ----------------------------------------------------------------------------
module rca_front
    import rca_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic              i_action,
    input  logic              i_first_of_frame,
    input  logic [PORT_W-1:0] i_in_red,
    input  logic [PORT_W-1:0] i_in_green,
    input  logic [PORT_W-1:0] i_in_blue,
    input  logic [PORT_W-1:0] i_in_opacity,
    input  logic              i_q_full,
    output logic              o_q_push,
    output t_item             o_q_item
);

    localparam int CB      = CHANNEL_BITS;
    localparam int SUM_W   = CB + 2;
    localparam int DIV3_SH = CB + 3;
    localparam int RCP3_W  = CB + 2;
    localparam int PROD_W  = SUM_W + RCP3_W;
    // ceil(2^DIV3_SH / 3): exact floor division by three for any sum below 2^SUM_W.
    localparam logic [RCP3_W-1:0] RCP3 = RCP3_W'(((64'd1 << DIV3_SH) + 64'd2) / 64'd3);

    logic              r_v;
    logic              r_action;
    logic              r_first;
    logic [CB-1:0]     r_red;
    logic [CB-1:0]     r_green;
    logic [CB-1:0]     r_blue;
    logic [PORT_W-1:0] r_opacity;
    logic              accept;
    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;
    logic [CB-1:0]     bright;

    assign o_full   = r_v && i_q_full;
    assign accept   = i_push && !o_full;
    assign o_q_push = r_v && !i_q_full;

    assign sum    = SUM_W'(r_red) + SUM_W'(r_green) + SUM_W'(r_blue);
    assign prod   = PROD_W'(sum) * PROD_W'(RCP3);
    assign bright = prod[DIV3_SH+CB-1:DIV3_SH];

    always_comb begin
        o_q_item         = '0;
        o_q_item.action  = r_action;
        o_q_item.first   = r_first;
        o_q_item.red     = PORT_W'(r_red);
        o_q_item.green   = PORT_W'(r_green);
        o_q_item.blue    = PORT_W'(r_blue);
        o_q_item.opacity = r_opacity;
        o_q_item.bright  = PORT_W'(bright);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (accept) begin
            r_v <= 1'b1;
        end else if (o_q_push) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action  <= i_action;
            r_first   <= i_first_of_frame;
            r_red     <= i_in_red[CB-1:0];
            r_green   <= i_in_green[CB-1:0];
            r_blue    <= i_in_blue[CB-1:0];
            r_opacity <= i_in_opacity;
        end
    end

endmodule

FILE: rtl/rca_div.sv
// ----------------------------------------------------------------------------
// rca_div: restoring divider for the auto contrast gain
// Produces one quotient bit per cycle; done pulses once the quotient is final.
// ----------------------------------------------------------------------------
module rca_div
    import rca_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [CHANNEL_BITS+FRAC_W-1:0]   i_dividend,
    input  logic [CHANNEL_BITS-1:0]          i_divisor,
    output logic                             o_done,
    output logic [CHANNEL_BITS+FRAC_W-1:0]   o_quotient
);

    localparam int DW    = CHANNEL_BITS + FRAC_W;
    localparam int DV    = CHANNEL_BITS;
    localparam int CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DV-1:0]    r_rem;
    logic [DV-1:0]    r_dvs;
    logic [DW-1:0]    r_quo;
    logic [DV:0]      rem_sh;
    logic             fits;
    logic [DV:0]      rem_nx;

    assign rem_sh = {r_rem, r_quo[DW-1]};
    assign fits   = (rem_sh >= {1'b0, r_dvs});
    assign rem_nx = fits ? rem_sh - {1'b0, r_dvs} : rem_sh;

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], fits};
            r_rem <= rem_nx[DV-1:0];
        end
    end

endmodule

FILE: rtl/rca_back.sv
// ----------------------------------------------------------------------------
// rca_back: execution side of the contrast adjuster
// Keeps the brightness statistics and gain, and runs adjust items through
// a three-stage pipeline of per-channel lanes into the result queue.
// ----------------------------------------------------------------------------
module rca_back
    import rca_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [7:0]          i_cfg_wr_data,
    input  logic                i_q_empty,
    input  t_item               i_q_item,
    output logic                o_q_pop,
    input  logic [OQ_CNT_W-1:0] i_oq_count,
    output logic                o_oq_push,
    output t_pixel              o_oq_pixel
);

    localparam int CB   = CHANNEL_BITS;
    localparam logic [CB-1:0] CMAX = CB'((1 << CB) - 1);
    localparam logic [CB-1:0] MID  = CB'((1 << (CB - 1)) - 1);
    localparam int DW   = CB + FRAC_W;
    localparam int PW   = GAIN_W + CB;
    localparam int NW   = CB + 13;
    localparam int S127 = CB + 20;
    localparam int RW   = CB + 14;
    localparam int QW   = CB + 8;
    localparam int SW   = CB + 10;
    localparam int CW   = OQ_CNT_W + 1;
    localparam int LANES = 3;
    // ceil(2^S127 / 127): exact floor division by 127 for products below 2^NW.
    localparam logic [RW-1:0] RCP127 = RW'(((64'd1 << S127) + 64'd126) / 64'd127);

    typedef enum logic [1:0] {
        ST_RUN = 2'b01,
        ST_DIV = 2'b10
    } t_state;

    t_state                    r_state;
    logic signed [7:0]         r_factor;
    logic [13:0]               r_k;
    logic [CB-1:0]             r_min;
    logic [CB-1:0]             r_max;
    logic [GAIN_W-1:0]         r_gain;
    logic                      r_gain_ok;

    logic                      r_v1;
    logic                      r_v2;
    logic                      r_v3;
    logic                      r1_auto;
    logic [PORT_W-1:0]         r1_opac;
    logic [PORT_W-1:0]         r2_opac;
    logic [PORT_W-1:0]         r3_opac;
    logic [PW-1:0]             r1_p    [LANES];
    logic                      r1_neg  [LANES];
    logic [CB-1:0]             r1_base [LANES];
    logic [QW-1:0]             r2_q    [LANES];
    logic                      r2_neg  [LANES];
    logic [CB-1:0]             r2_base [LANES];
    logic [CB-1:0]             r3_val  [LANES];

    logic                      is_auto;
    logic                      is_neg;
    logic [7:0]                k_neg8;
    logic [GAIN_W-1:0]         k_sel;
    logic                      head_adj;
    logic                      need_gain;
    logic                      credit_ok;
    logic                      issue;
    logic                      measure;
    logic [CB-1:0]             bright;
    logic [CB-1:0]             hi_room;
    logic [CB-1:0]             border;
    logic                      den_le0;
    logic [CB-1:0]             den;
    logic                      div_start;
    logic                      div_done;
    logic [DW-1:0]             div_q;
    logic [GAIN_W-1:0]         gain_nx;
    logic [CB-1:0]             chan_in [LANES];

    assign is_auto = (r_factor == AUTO_CODE);
    assign is_neg  = r_factor[7] && !is_auto;
    assign k_neg8  = 8'd127 + r_factor;
    assign k_sel   = is_auto ? r_gain : GAIN_W'(r_k);

    assign head_adj  = (i_q_item.action == ACT_ADJUST);
    assign need_gain = head_adj && is_auto && !r_gain_ok;
    assign credit_ok = ({1'b0, i_oq_count} + CW'(r_v1) + CW'(r_v2) + CW'(r_v3))
                       < CW'(OQ_DEPTH);
    assign o_q_pop   = (r_state == ST_RUN) && !i_q_empty
                       && (!head_adj || (!need_gain && credit_ok));
    assign issue     = o_q_pop && head_adj;
    assign measure   = o_q_pop && !head_adj;
    assign bright    = i_q_item.bright[CB-1:0];

    // Auto gain border and denominator.
    assign hi_room   = CMAX - r_max;
    assign border    = (r_min < hi_room) ? r_min : hi_room;
    assign den_le0   = (border >= MID);
    assign den       = MID - border;
    assign div_start = (r_state == ST_RUN) && !i_q_empty && need_gain && !den_le0;
    assign gain_nx   = (DW'(GAIN_MAX) < div_q) ? GAIN_MAX : GAIN_W'(div_q);

    assign chan_in[0] = i_q_item.red[CB-1:0];
    assign chan_in[1] = i_q_item.green[CB-1:0];
    assign chan_in[2] = i_q_item.blue[CB-1:0];

    rca_div #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({border, FRAC_W'(0)}),
        .i_divisor  (den),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Configuration, statistics, gain and sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_RUN;
            r_factor  <= '0;
            r_k       <= '0;
            r_min     <= CMAX;
            r_max     <= '0;
            r_gain    <= '0;
            r_gain_ok <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_factor <= i_cfg_wr_data;
            end
            r_k <= r_factor[7] ? 14'(k_neg8)
                               : 14'(r_factor[6:0]) * 14'(r_factor[6:0]);
            unique case (r_state)
                ST_RUN: begin
                    if (measure) begin
                        r_gain_ok <= 1'b0;
                        if (i_q_item.first) begin
                            r_min <= bright;
                            r_max <= bright;
                        end else begin
                            if (bright < r_min) begin
                                r_min <= bright;
                            end
                            if (bright > r_max) begin
                                r_max <= bright;
                            end
                        end
                    end else if (!i_q_empty && need_gain) begin
                        if (den_le0) begin
                            r_gain    <= GAIN_MAX;
                            r_gain_ok <= 1'b1;
                        end else begin
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_gain    <= gain_nx;
                        r_gain_ok <= 1'b1;
                        r_state   <= ST_RUN;
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase
        end
    end

    // Pipeline valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r1_auto <= is_auto;
            r1_opac <= i_q_item.opacity;
        end
        if (r_v1) begin
            r2_opac <= r1_opac;
        end
        if (r_v2) begin
            r3_opac <= r2_opac;
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic                  d_neg;
        logic [CB-1:0]         d_mag;
        logic [NW+RW-1:0]      prod127;
        logic signed [SW-1:0]  base_s;
        logic signed [SW-1:0]  q_s;
        logic signed [SW-1:0]  sum;
        logic [CB-1:0]         clamped;

        // Magnitude and sign of the deviation from mid level.
        assign d_neg = (chan_in[l] < MID);
        assign d_mag = d_neg ? MID - chan_in[l] : chan_in[l] - MID;

        assign prod127 = (NW+RW)'(r1_p[l][NW-1:0]) * (NW+RW)'(RCP127);

        assign base_s = signed'(SW'(r2_base[l]));
        assign q_s    = signed'(SW'(r2_q[l]));
        assign sum    = r2_neg[l] ? base_s - q_s : base_s + q_s;

        always_comb begin
            if (sum[SW-1]) begin
                clamped = '0;
            end else if (sum > signed'(SW'(CMAX))) begin
                clamped = CMAX;
            end else begin
                clamped = sum[CB-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (issue) begin
                r1_p[l]    <= PW'(k_sel) * PW'(d_mag);
                r1_neg[l]  <= d_neg;
                r1_base[l] <= is_neg ? MID : chan_in[l];
            end
            if (r_v1) begin
                r2_q[l]    <= r1_auto ? QW'(r1_p[l][PW-1:FRAC_W])
                                      : QW'(prod127[NW+RW-1:S127]);
                r2_neg[l]  <= r1_neg[l];
                r2_base[l] <= r1_base[l];
            end
            if (r_v2) begin
                r3_val[l] <= clamped;
            end
        end
    end

    assign o_oq_push          = r_v3;
    assign o_oq_pixel.red     = PORT_W'(r3_val[0]);
    assign o_oq_pixel.green   = PORT_W'(r3_val[1]);
    assign o_oq_pixel.blue    = PORT_W'(r3_val[2]);
    assign o_oq_pixel.opacity = r3_opac;

endmodule

FILE: rtl/rca_checker.sv
// ----------------------------------------------------------------------------
// rca_checker: port-level checks for the contrast adjuster
// Watches the queue-style ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module rca_checker
    import rca_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input logic [PORT_W-1:0] o_out_red,
    input logic [PORT_W-1:0] o_out_green,
    input logic [PORT_W-1:0] o_out_blue,
    input logic [PORT_W-1:0] o_out_opacity
);

    // After reset no result is waiting and the input is open.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    // A result that is not taken stays available.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty)
        else $error("waiting result lost");

    // A result that is not taken keeps its value.
    a_result_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable(o_out_red) && $stable(o_out_green)
                           && $stable(o_out_blue) && $stable(o_out_opacity))
        else $error("waiting result changed");

    // Adjusted channels are clamped to the channel range.
    a_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_out_red >> CHANNEL_BITS) == PORT_W'(0))
                   && ((o_out_green >> CHANNEL_BITS) == PORT_W'(0))
                   && ((o_out_blue >> CHANNEL_BITS) == PORT_W'(0)))
        else $error("adjusted channel out of range");

endmodule

bind rgb16_contrast_adjust rca_checker #(
    .CHANNEL_BITS (CHANNEL_BITS)
) u_rca_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_out_red     (o_out_red),
    .o_out_green   (o_out_green),
    .o_out_blue    (o_out_blue),
    .o_out_opacity (o_out_opacity)
);
